// ===== sv/iqr_outlier_test_defines.svh =====
// Assertion macros shared by the IQR outlier test checker.
`ifndef IQR_OUTLIER_TEST_DEFINES_SVH
`define IQR_OUTLIER_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iqr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define IQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iqr assertion failed");

`endif

// ===== sv/iqr_pkg.sv =====
// Package for the IQR outlier test: sizes, mode codes, beat and control types.
package iqr_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int MULT_BITS    = 12;
    localparam int FRAC_BITS    = 8;
    localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);
    localparam int SPREAD_BITS  = SAMPLE_BITS + MULT_BITS;
    localparam int FENCE_BITS   = SAMPLE_BITS + MULT_BITS + 2;

    localparam logic [MULT_BITS-1:0] MULT_RESET = MULT_BITS'(384);

    // Input mode codes; the fourth code is ignored
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEST   = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [1:0] mode;
        t_sample    value;
    } t_in_item;

    typedef struct packed {
        logic    is_outlier;
        logic    window_empty;
        logic    window_overflowed;
        t_sample lower_quartile;
        t_sample upper_quartile;
    } t_out_item;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                ins_en;
        t_sample             sample;
        logic [CNT_BITS-1:0] count;
        logic [IDX_BITS-1:0] i1;
        logic [IDX_BITS-1:0] i3;
    } t_cell_ctl;

endpackage

// ===== sv/iqr_cell.sv =====
// One cell of the sorted window chain: insertion shift and quartile scan.
module iqr_cell (
    input  logic                          i_clk,
    input  iqr_pkg::t_cell_ctl            i_ctl,
    input  logic [iqr_pkg::IDX_BITS-1:0]  i_index,
    input  iqr_pkg::t_sample              i_left_val,
    input  logic                          i_left_gt,
    input  iqr_pkg::t_sample              i_left_q1,
    input  iqr_pkg::t_sample              i_left_q3,
    output iqr_pkg::t_sample              o_val,
    output logic                          o_gt,
    output iqr_pkg::t_sample              o_q1,
    output iqr_pkg::t_sample              o_q3
);
    import iqr_pkg::*;

    t_sample r_val;
    t_sample r_q1;
    t_sample r_q3;
    logic    occupied;
    logic    gt;

    // An empty slot counts as greater so the new sample lands in it
    assign occupied = CNT_BITS'(i_index) < i_ctl.count;
    assign gt       = !occupied || (r_val > i_ctl.sample);

    assign o_val = r_val;
    assign o_gt  = gt;
    assign o_q1  = r_q1;
    assign o_q3  = r_q3;

    // Insertion: shift right where greater, take the sample at the boundary
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && gt) begin
            r_val <= i_left_gt ? i_left_val : i_ctl.sample;
        end
    end

    // Scan: the selected entries ripple down the chain one cell per cycle
    always_ff @(posedge i_clk) begin
        r_q1 <= i_left_q1 | ((i_index == i_ctl.i1) ? r_val : '0);
        r_q3 <= i_left_q3 | ((i_index == i_ctl.i3) ? r_val : '0);
    end

endmodule

// ===== sv/iqr_fence.sv =====
// Fence unit: registered spread multiply, then exact fence compare.
module iqr_fence (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  iqr_pkg::t_sample               i_q1,
    input  iqr_pkg::t_sample               i_q3,
    input  logic [iqr_pkg::MULT_BITS-1:0]  i_mult,
    input  iqr_pkg::t_sample               i_value,
    output logic                           o_is_outlier,
    output iqr_pkg::t_sample               o_q1,
    output iqr_pkg::t_sample               o_q3
);
    import iqr_pkg::*;

    t_sample                 r_q1;
    t_sample                 r_q3;
    t_sample                 r_value;
    logic [SPREAD_BITS-1:0]  r_spread;

    logic signed [SAMPLE_BITS:0]  iqr_w;
    logic [SAMPLE_BITS-1:0]       iqr_u;
    logic signed [FENCE_BITS-1:0] q1_sc;
    logic signed [FENCE_BITS-1:0] q3_sc;
    logic signed [FENCE_BITS-1:0] v_sc;
    logic signed [FENCE_BITS-1:0] spread_x;
    logic signed [FENCE_BITS-1:0] fence_lo;
    logic signed [FENCE_BITS-1:0] fence_hi;

    // Q3 >= Q1 in a sorted window, so the range is non-negative
    assign iqr_w = (SAMPLE_BITS + 1)'(i_q3) - (SAMPLE_BITS + 1)'(i_q1);
    assign iqr_u = iqr_w[SAMPLE_BITS-1:0];

    // Stage 1: latch quartiles and value, multiply range by the Q4.8 factor
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q1     <= i_q1;
            r_q3     <= i_q3;
            r_value  <= i_value;
            r_spread <= SPREAD_BITS'(i_mult) * SPREAD_BITS'(iqr_u);
        end
    end

    // Stage 2: compare in Q.8 against both fences
    assign q1_sc    = FENCE_BITS'(r_q1) <<< FRAC_BITS;
    assign q3_sc    = FENCE_BITS'(r_q3) <<< FRAC_BITS;
    assign v_sc     = FENCE_BITS'(r_value) <<< FRAC_BITS;
    assign spread_x = $signed({2'b00, r_spread});
    assign fence_lo = q1_sc - spread_x;
    assign fence_hi = q3_sc + spread_x;

    assign o_is_outlier = (v_sc < fence_lo) || (v_sc > fence_hi);
    assign o_q1         = r_q1;
    assign o_q3         = r_q3;

endmodule

// ===== sv/iqr_outlier_test.sv =====
// Tukey IQR outlier test: a chain of sorting cells with a fence compare unit.
// A load beat (start or append) is done as it is taken: every cell of the chain
// compares the new sample at once and the larger entries shift one place
// right, keeping the window in ascending order. A test beat keeps the block
// busy from acceptance until its result is loaded: the quartile entries
// ripple down the cell chain one cell per cycle, then the fence unit
// registers the spread multiply and compares against the fences.
// The result sits in an output register; loads are accepted while it
// waits, and a further test completes once the previous result is taken.
// Appends into a full window are dropped and flagged as overflow until the
// next start beat. The fence multiplier register (unsigned Q4.8, reset 1.5)
// must only be written while the block is idle.
module iqr_outlier_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [iqr_pkg::MULT_BITS-1:0]  i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  iqr_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output iqr_pkg::t_out_item             o_out_data
);
    import iqr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_CMP  = 3'b100
    } t_state;

    t_state              r_state;
    logic [IDX_BITS-1:0] r_scan_cnt;
    logic [CNT_BITS-1:0] r_count;
    logic                r_ovf;
    logic [MULT_BITS-1:0] r_mult;
    t_sample             r_test_val;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic       in_acc;
    logic       full;
    logic       out_free;
    logic       scan_done;
    t_cell_ctl  ctl;
    logic       fence_outlier;
    t_sample    fence_q1;
    t_sample    fence_q3;

    t_sample chain_val [0:WINDOW_DEPTH-1];
    logic    chain_gt  [0:WINDOW_DEPTH-1];
    t_sample chain_q1  [0:WINDOW_DEPTH];
    t_sample chain_q3  [0:WINDOW_DEPTH];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign full        = (r_count == CNT_BITS'(WINDOW_DEPTH));
    assign out_free    = !r_out_valid || i_out_ready;
    assign scan_done   = (r_scan_cnt == IDX_BITS'(WINDOW_DEPTH - 1));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Cell control broadcast; a start beat sees an empty window
    always_comb begin
        ctl.sample = i_in_data.value;
        ctl.ins_en = 1'b0;
        ctl.count  = r_count;
        ctl.i1     = IDX_BITS'(r_count >> 2);
        ctl.i3     = IDX_BITS'(((CNT_BITS + 2)'(r_count) * 3) >> 2);
        if (in_acc) begin
            unique case (i_in_data.mode)
                MODE_START: begin
                    ctl.ins_en = 1'b1;
                    ctl.count  = '0;
                end
                MODE_APPEND: ctl.ins_en = !full;
                default:     ctl.ins_en = 1'b0;
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RESET;
        end else if (i_cfg_wr_en) begin
            r_mult <= i_cfg_wr_data;
        end
    end

    // Window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            unique case (i_in_data.mode)
                MODE_START: begin
                    r_count <= CNT_BITS'(1);
                    r_ovf   <= 1'b0;
                end
                MODE_APPEND: begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Test sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_data.mode == MODE_TEST)) begin
                        r_state    <= S_SCAN;
                        r_scan_cnt <= '0;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_CMP;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + IDX_BITS'(1);
                    end
                end
                S_CMP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Tested value held while the scan runs
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.mode == MODE_TEST)) begin
            r_test_val <= i_in_data.value;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_CMP) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_CMP) && out_free) begin
            r_out_data.window_empty      <= (r_count == '0);
            r_out_data.window_overflowed <= r_ovf;
            if (r_count == '0) begin
                r_out_data.is_outlier     <= 1'b0;
                r_out_data.lower_quartile <= '0;
                r_out_data.upper_quartile <= '0;
            end else begin
                r_out_data.is_outlier     <= fence_outlier;
                r_out_data.lower_quartile <= fence_q1;
                r_out_data.upper_quartile <= fence_q3;
            end
        end
    end

    // Cell chain
    assign chain_q1[0] = '0;
    assign chain_q3[0] = '0;

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            iqr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_index    (IDX_BITS'(k)),
                .i_left_val ('0),
                .i_left_gt  (1'b0),
                .i_left_q1  (chain_q1[k]),
                .i_left_q3  (chain_q3[k]),
                .o_val      (chain_val[k]),
                .o_gt       (chain_gt[k]),
                .o_q1       (chain_q1[k+1]),
                .o_q3       (chain_q3[k+1])
            );
        end else begin : g_mid
            iqr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_index    (IDX_BITS'(k)),
                .i_left_val (chain_val[k-1]),
                .i_left_gt  (chain_gt[k-1]),
                .i_left_q1  (chain_q1[k]),
                .i_left_q3  (chain_q3[k]),
                .o_val      (chain_val[k]),
                .o_gt       (chain_gt[k]),
                .o_q1       (chain_q1[k+1]),
                .o_q3       (chain_q3[k+1])
            );
        end
    end

    // Fence compare, loaded as the scan finishes
    iqr_fence u_fence (
        .i_clk        (i_clk),
        .i_load       ((r_state == S_SCAN) && scan_done),
        .i_q1         (chain_q1[WINDOW_DEPTH]),
        .i_q3         (chain_q3[WINDOW_DEPTH]),
        .i_mult       (r_mult),
        .i_value      (r_test_val),
        .o_is_outlier (fence_outlier),
        .o_q1         (fence_q1),
        .o_q3         (fence_q3)
    );

endmodule

// ===== sv/iqr_checker.sv =====
// Port-level checker for the IQR outlier test, bound to the top level.
`include "iqr_outlier_test_defines.svh"

module iqr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  iqr_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  iqr_pkg::t_out_item  i_out_data
);
    import iqr_pkg::*;

    // A stalled result beat holds
    `IQR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // An empty window never flags and reports zero quartiles
    `IQR_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_data.window_empty, !i_out_data.is_outlier && (i_out_data.lower_quartile == '0) && (i_out_data.upper_quartile == '0))

    // Quartiles come from a sorted window
    `IQR_ASSERT_IMP(a_quart_order, i_clk, i_rst_n, i_out_valid && !i_out_data.window_empty, i_out_data.lower_quartile <= i_out_data.upper_quartile)

    // A test beat occupies the block for the scan
    `IQR_ASSERT_NXT(a_test_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_data.mode == MODE_TEST), !i_in_ready)

endmodule

bind iqr_outlier_test iqr_checker u_iqr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ===== test/iqr_fence_checker.sv =====
// Checker for the IQR outlier block: mirrors the sorted window and compares each test result.
`timescale 1ns / 100ps

module iqr_fence_checker
    import iqr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [MULT_BITS-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    // Mirror of the block state
    t_sample              sorted_mirror [WINDOW_DEPTH];
    int                   mirror_fill;
    logic                 mirror_dropped;
    logic [MULT_BITS-1:0] fence_mult;

    // Expected test results, oldest first
    t_out_item            fence_results_q [$];
    int                   results_seen;

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: result %0d: %s", $time, results_seen, what);
        o_fail_count++;
    endtask

    // Insertion after any equal entries keeps the mirror ascending
    function automatic void insert_sorted(input t_sample s);
        int pos;
        pos = mirror_fill;
        while (pos > 0 && sorted_mirror[pos-1] > s) begin
            sorted_mirror[pos] = sorted_mirror[pos-1];
            pos--;
        end
        sorted_mirror[pos] = s;
        mirror_fill++;
    endfunction

    // Quartile pick and exact fence compare in Q.8 scaled integers
    function automatic t_out_item predict_fences(input t_sample v);
        t_out_item r;
        int        i1;
        int        i3;
        longint    q1;
        longint    q3;
        longint    spread;
        longint    scaled;
        r = '0;
        r.window_empty      = (mirror_fill == 0);
        r.window_overflowed = mirror_dropped;
        if (mirror_fill > 0) begin
            i1 = mirror_fill / 4;
            i3 = (3 * mirror_fill) / 4;
            if (i1 > WINDOW_DEPTH - 1) i1 = WINDOW_DEPTH - 1;
            if (i3 > WINDOW_DEPTH - 1) i3 = WINDOW_DEPTH - 1;
            q1     = sorted_mirror[i1];
            q3     = sorted_mirror[i3];
            spread = longint'(fence_mult) * (q3 - q1);
            scaled = longint'(v) <<< FRAC_BITS;
            r.is_outlier = (scaled < (q1 <<< FRAC_BITS) - spread) ||
                           (scaled > (q3 <<< FRAC_BITS) + spread);
            r.lower_quartile = sorted_mirror[i1];
            r.upper_quartile = sorted_mirror[i3];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mirror_fill    = 0;
            mirror_dropped = 1'b0;
            fence_mult     = MULT_RESET;
            fence_results_q.delete();
            results_seen   = 0;
            o_pending      = 0;
            o_fail_count   = 0;
        end else begin
            if (i_cfg_wr_en)
                fence_mult = i_cfg_wr_data;

            // Input beat: update the mirror or queue a prediction
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.mode)
                    MODE_START: begin
                        mirror_fill    = 0;
                        mirror_dropped = 1'b0;
                        insert_sorted(i_in_data.value);
                    end
                    MODE_APPEND: begin
                        if (mirror_fill >= WINDOW_DEPTH)
                            mirror_dropped = 1'b1;
                        else
                            insert_sorted(i_in_data.value);
                    end
                    MODE_TEST: begin
                        fence_results_q.push_back(predict_fences(i_in_data.value));
                    end
                    default: ; // fourth code does nothing
                endcase
            end

            // Output beat: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (fence_results_q.size() == 0) begin
                    report_mismatch("result beat with no test outstanding");
                end else begin
                    want = fence_results_q.pop_front();
                    if (i_out_data.is_outlier !== want.is_outlier)
                        report_mismatch($sformatf("is_outlier got %b want %b",
                            i_out_data.is_outlier, want.is_outlier));
                    if (i_out_data.window_empty !== want.window_empty)
                        report_mismatch($sformatf("window_empty got %b want %b",
                            i_out_data.window_empty, want.window_empty));
                    if (i_out_data.window_overflowed !== want.window_overflowed)
                        report_mismatch($sformatf("window_overflowed got %b want %b",
                            i_out_data.window_overflowed, want.window_overflowed));
                    if (i_out_data.lower_quartile !== want.lower_quartile)
                        report_mismatch($sformatf("lower_quartile got %0d want %0d",
                            i_out_data.lower_quartile, want.lower_quartile));
                    if (i_out_data.upper_quartile !== want.upper_quartile)
                        report_mismatch($sformatf("upper_quartile got %0d want %0d",
                            i_out_data.upper_quartile, want.upper_quartile));
                end
                results_seen++;
            end
            o_pending = fence_results_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the IQR outlier block: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import iqr_pkg::*;

    localparam logic [1:0] MODE_IGNORED  = 2'd3;
    localparam int         ITEMS_TOTAL   = 1600;
    localparam int         NUM_PHASES    = 7;
    localparam int         SETTLE_CYCLES = WINDOW_DEPTH + 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         TIMEOUT_NS    = 4_000_000;
    localparam t_sample    SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample    SAMPLE_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [MULT_BITS-1:0] cfg_wr_data;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_data;
    int                   pending;
    int                   fail_count;

    // Stimulus controls; calm and hold_req are shared with the receiver
    logic                 calm;
    logic                 hold_req;
    int                   beats_sent;
    t_sample              center;
    int                   spread_style;

    iqr_outlier_test u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data)
    );

    iqr_fence_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: random stalls, calm stretches, one long hold-off on request
    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Window samples: extremes now and then, otherwise by the window's spread
    function automatic t_sample draw_sample();
        int r;
        r = $urandom_range(99);
        if (r < 3) return SAMPLE_MIN;
        if (r < 6) return SAMPLE_MAX;
        case (spread_style)
            0:       return t_sample'($urandom);
            1:       return t_sample'(int'(center) + int'($urandom_range(8)) - 4);
            2:       return t_sample'(int'(center) + int'($urandom_range(128)) - 64);
            default: return t_sample'(int'(center) + int'($urandom_range(4096)) - 2048);
        endcase
    endfunction

    // Test values: in the window's range, a bit wider, or anywhere
    function automatic t_sample draw_probe();
        int r;
        r = $urandom_range(99);
        if (r < 50) return draw_sample();
        if (r < 60) return center;
        if (r < 85) return t_sample'(int'(center) + int'($urandom_range(16384)) - 8192);
        return t_sample'($urandom);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(15, 0);
        if (r < 94) return $urandom_range(62, 16);
        return $urandom_range(70, 63);
    endfunction

    // One input beat; entered and left at a falling edge
    task automatic send_beat(input logic [1:0] mode, input t_sample value);
        t_in_item beat;
        beat.mode  = mode;
        beat.value = value;
        while (!calm && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (mode != MODE_IGNORED) beats_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every test result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_multiplier(input logic [MULT_BITS-1:0] m);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Start a window, fill it, test it; a little noise mixed in
    task automatic run_window(input int n_appends);
        int r;
        int n_tests;
        center       = t_sample'($urandom);
        spread_style = $urandom_range(3);
        send_beat(MODE_START, draw_sample());
        for (int k = 0; k < n_appends; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_beat(MODE_IGNORED, t_sample'($urandom));
            else if (r < 10)
                send_beat(MODE_TEST, draw_probe());
            send_beat(MODE_APPEND, draw_sample());
        end
        n_tests = $urandom_range(4, 1);
        for (int k = 0; k < n_tests; k++) begin
            send_beat(MODE_TEST, draw_probe());
            if ($urandom_range(9) == 0)
                send_beat(MODE_APPEND, draw_sample());
        end
    endtask

    initial begin
        logic [MULT_BITS-1:0] mult_plan [NUM_PHASES];
        int                   goal;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        beats_sent   = 0;
        center       = '0;
        spread_style = 0;

        // Phase 0 keeps the reset multiplier; extremes come next
        mult_plan[0] = MULT_RESET;
        mult_plan[1] = '0;
        mult_plan[2] = '1;
        mult_plan[3] = MULT_BITS'(256);
        mult_plan[4] = MULT_BITS'(1);
        mult_plan[5] = MULT_BITS'($urandom);
        mult_plan[6] = MULT_BITS'($urandom);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty window after reset, and the unused mode
        send_beat(MODE_TEST, '0);
        send_beat(MODE_IGNORED, t_sample'(16'h1234));
        send_beat(MODE_TEST, t_sample'(-1));
        // Single sample: both quartiles are that sample
        send_beat(MODE_START, SAMPLE_MAX);
        send_beat(MODE_TEST, SAMPLE_MAX);
        // Field extremes and equal samples
        send_beat(MODE_APPEND, SAMPLE_MIN);
        send_beat(MODE_APPEND, '0);
        send_beat(MODE_APPEND, '0);
        send_beat(MODE_APPEND, t_sample'(-1));
        send_beat(MODE_APPEND, t_sample'(1));
        send_beat(MODE_TEST, SAMPLE_MIN);
        send_beat(MODE_TEST, SAMPLE_MAX);
        send_beat(MODE_TEST, '0);
        send_beat(MODE_APPEND, t_sample'(16'h5555));
        send_beat(MODE_APPEND, t_sample'(16'hAAAA));
        send_beat(MODE_TEST, t_sample'(16'hAAAA));
        send_beat(MODE_IGNORED, t_sample'(16'hFFFF));
        send_beat(MODE_TEST, t_sample'(16'h5555));

        // Full window with dropped appends, then a fresh start clears the flag
        run_window(WINDOW_DEPTH + 2);
        run_window(3);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0)
                write_multiplier(mult_plan[p]);
            calm = (p == 2);
            if (p == 4) begin
                // Long receiver hold-off while tests keep coming
                hold_req = 1'b1;
                run_window(8);
                for (int k = 0; k < 6; k++)
                    send_beat(MODE_TEST, draw_probe());
                drain_results();
            end
            goal = ((p + 1) * ITEMS_TOTAL) / NUM_PHASES;
            while (beats_sent < goal)
                run_window(pick_length());
            if (p == 5)
                drain_results();
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
